### rtl/core/dwmb_pkg.sv
// shared types and constants for the diamond window mean blur
`timescale 1ns / 1ps
package dwmb_pkg;

  localparam int PIX_W    = 8;
  localparam int COORD_W  = 8;
  localparam int RADIUS_W = 4;
  localparam int STEP_W   = 3;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd1;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_START,
    ST_DIV,
    ST_RESULT
  } state_e;

endpackage

### rtl/core/dwmb_frame_mem.sv
// frame store, one write port and one registered read port
`timescale 1ns / 1ps
module dwmb_frame_mem #(
  parameter int ADDR_W = 16
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic [dwmb_pkg::PIX_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic [dwmb_pkg::PIX_W-1:0] rdata_o
);
  import dwmb_pkg::*;

  logic [PIX_W-1:0] mem_q [2**ADDR_W];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/dwmb_div.sv
// bit-serial divider, quotient known to fit in one pixel
`timescale 1ns / 1ps
module dwmb_div #(
  parameter int SUM_W = 17,
  parameter int CNT_W = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SUM_W-1:0]           sum_i,
  input  logic [CNT_W-1:0]           cnt_i,
  output logic                       done_o,
  output logic [dwmb_pkg::PIX_W-1:0] quot_o
);
  import dwmb_pkg::*;

  localparam int DSH_W = CNT_W + PIX_W - 1;
  localparam int XW    = (DSH_W > SUM_W) ? DSH_W : SUM_W;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [DSH_W-1:0]  dsh_q, dsh_d;
  logic [PIX_W-1:0]  quot_q, quot_d;
  logic              ge;
  logic [XW-1:0]     diff;

  assign ge   = XW'(rem_q) >= XW'(dsh_q);
  assign diff = XW'(rem_q) - XW'(dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(PIX_W - 1);
      rem_d  = sum_i;
      dsh_d  = {cnt_i, {(PIX_W-1){1'b0}}};
      quot_d = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = diff[SUM_W-1:0];
      end
      quot_d = {quot_q[PIX_W-2:0], ge};
      dsh_d  = dsh_q >> 1;
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/core/diamond_window_mean_blur_top.sv
// Diamond window mean blur: a load request writes one pixel into the frame store (nothing
// when its coordinate is off the image) and gives no result. A query request walks the
// diamond of Manhattan radius r around the point row by row, visiting its 2r(r+1)+1
// diamond positions at one per cycle and issuing a frame-store read for each one on the
// image (positions off the image are skipped but still take their turn), then averages
// with a bit-serial divider. The next request is taken only once the result of a query
// has been written to the output register. The single frame-store read port paces the
// walk. A query with a coordinate off the image skips the walk and returns zero. The
// result sits in an output register, so the next request is taken while it waits.
`timescale 1ns / 1ps
module diamond_window_mean_blur_top #(
  parameter int IMAGE_SIDE = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dwmb_pkg::RADIUS_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [dwmb_pkg::COORD_W-1:0]  row_i,
  input  logic [dwmb_pkg::COORD_W-1:0]  col_i,
  input  logic [dwmb_pkg::PIX_W-1:0]    pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dwmb_pkg::PIX_W-1:0]    blurred_o
);
  import dwmb_pkg::*;

  localparam int AC      = $clog2(IMAGE_SIDE);
  localparam int CW      = (AC > COORD_W) ? AC : COORD_W;
  localparam int SW      = CW + 2;
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int DW      = RW + 1;
  localparam int RXW     = (RW > RADIUS_W) ? RW : RADIUS_W;
  localparam int MAX_CNT = 2 * MAX_RADIUS * (MAX_RADIUS + 1) + 1;
  localparam int CNTW    = $clog2(MAX_CNT + 1);
  localparam int SUMW    = $clog2(MAX_CNT * 255 + 1);
  localparam int ADDR_W  = 2 * AC;

  localparam logic [SW-1:0]  SIDE_S  = SW'(IMAGE_SIDE);
  localparam logic [RXW-1:0] RMAX_X  = RXW'(MAX_RADIUS);

  state_e             state_q, state_d;
  logic [RADIUS_W-1:0] radius_q;
  logic [RW-1:0]      r_q, r_d;
  logic [SW-1:0]      qrow_q, qrow_d, qcol_q, qcol_d;
  logic [DW-1:0]      dr_q, dr_d, dc_q, dc_d;
  logic [SUMW-1:0]    sum_q, sum_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic               rd_vld_q, rd_vld_d;
  logic [PIX_W-1:0]   res_q, res_d;
  logic               out_valid_q, out_valid_d;
  logic [PIX_W-1:0]   blurred_q, blurred_d;

  logic [SW-1:0]      row_ext, col_ext;
  logic               load_in, accept;
  logic [RXW-1:0]     rad_ext;
  logic [RW-1:0]      r_eff;
  logic [SW-1:0]      y, x;
  logic               y_in, x_in;
  logic [DW-1:0]      abs_dr, dr_nx, abs_nx;
  logic [RW-1:0]      span, span_nx;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [PIX_W-1:0]   rdata;
  logic               div_start, div_done;
  logic [PIX_W-1:0]   quot;

  assign row_ext = SW'(row_i);
  assign col_ext = SW'(col_i);
  assign accept  = in_valid_i && !in_stall_o;
  assign load_in = (row_ext < SIDE_S) && (col_ext < SIDE_S);
  assign rad_ext = RXW'(radius_q);
  assign r_eff   = (rad_ext > RMAX_X) ? RW'(MAX_RADIUS) : rad_ext[RW-1:0];

  // current diamond position
  assign y      = qrow_q + {{(SW-DW){dr_q[DW-1]}}, dr_q};
  assign x      = qcol_q + {{(SW-DW){dc_q[DW-1]}}, dc_q};
  assign y_in   = !y[SW-1] && (y < SIDE_S);
  assign x_in   = !x[SW-1] && (x < SIDE_S);
  assign abs_dr = dr_q[DW-1] ? (~dr_q + 1'b1) : dr_q;
  assign span   = r_q - abs_dr[RW-1:0];
  assign dr_nx  = dr_q + 1'b1;
  assign abs_nx = dr_nx[DW-1] ? (~dr_nx + 1'b1) : dr_nx;
  assign span_nx = r_q - abs_nx[RW-1:0];

  assign mem_we = accept && (req_type_i == REQ_LOAD) && load_in;
  assign waddr  = {row_ext[AC-1:0], col_ext[AC-1:0]};
  assign raddr  = {y[AC-1:0], x[AC-1:0]};

  dwmb_frame_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (pixel_i),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dwmb_div #(
    .SUM_W (SUMW),
    .CNT_W (CNTW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_q),
    .cnt_i   (cnt_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    qrow_d      = qrow_q;
    qcol_d      = qcol_q;
    dr_d        = dr_q;
    dc_d        = dc_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    blurred_d   = blurred_q;
    mem_re      = 1'b0;
    div_start   = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // accumulate data read in the previous cycle
    if (rd_vld_q) begin
      sum_d = sum_q + SUMW'(rdata);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_QUERY)) begin
          r_d    = r_eff;
          qrow_d = row_ext;
          qcol_d = col_ext;
          dr_d   = ~{1'b0, r_eff} + 1'b1;
          dc_d   = '0;
          sum_d  = '0;
          cnt_d  = '0;
          if (load_in) begin
            state_d = ST_SCAN;
          end else begin
            res_d   = '0;
            state_d = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (y_in && x_in) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + CNTW'(1);
        end
        if (dc_q == {1'b0, span}) begin
          if (dr_q == {1'b0, r_q}) begin
            state_d = ST_DRAIN;
          end else begin
            dr_d = dr_nx;
            dc_d = ~{1'b0, span_nx} + 1'b1;
          end
        end else begin
          dc_d = dc_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_d   = quot;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          blurred_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= RADIUS_RESET;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q       <= r_d;
    qrow_q    <= qrow_d;
    qcol_q    <= qcol_d;
    dr_q      <= dr_d;
    dc_q      <= dc_d;
    sum_q     <= sum_d;
    cnt_q     <= cnt_d;
    res_q     <= res_d;
    blurred_q <= blurred_d;
  end

  assign out_valid_o = out_valid_q;
  assign blurred_o   = blurred_q;

endmodule

### rtl/core/dwmb_checker.sv
// port-level checks for the diamond window mean blur, bound to the top level
`timescale 1ns / 1ps
module dwmb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       req_type_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [dwmb_pkg::PIX_W-1:0] blurred_o
);
  import dwmb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(blurred_o))
    else $error("stalled result changed");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("load request produced a result");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_QUERY) |=> in_stall_o)
    else $error("query request did not block the input");

endmodule

bind diamond_window_mean_blur_top dwmb_checker u_dwmb_checker (.*);
